FILE: src/mlpd_pkg.sv
package mlpd_pkg;

   localparam int unsigned HeaderLen   = 8;
   localparam int unsigned CountBits   = 3;
   localparam int unsigned HeaderBits  = 56;
   localparam int unsigned MaxLenBits  = 31;
   localparam int unsigned CsrIdxBits  = 2;
   localparam int unsigned CsrDataBits = 32;

   localparam logic [31:0] MagicReset  = 32'h5443_504D;
   localparam logic [MaxLenBits-1:0] MaxLenReset = 31'h7FFF_FFFF;

   localparam logic [CountBits-1:0] LastHeaderCount = CountBits'(HeaderLen - 1);

   localparam logic [CsrIdxBits-1:0] CsrMagicWord  = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrMaxLength  = 2'd1;

   typedef enum logic [1:0] {
      KindPayload   = 2'd0,
      KindEmpty     = 2'd1,
      KindBadMagic  = 2'd2,
      KindBadLength = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      kind_type   out_kind;
   } result_type;

endpackage

FILE: src/mlpd_if.sv
interface mlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface mlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [1:0] out_kind;

   modport source (output valid, output out_byte, output out_last, output out_kind,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input out_kind,
                   output ready);
endinterface

interface mlpd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/mlpd_in_stage.sv
module mlpd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [7:0] load_byte,
   input  logic       take,
   output logic       word_valid,
   output logic [7:0] word_byte
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = load_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign word_valid = valid_ff;
   assign word_byte  = byte_ff;
endmodule

FILE: src/mlpd_parser.sv
module mlpd_parser #(
   parameter int unsigned LENGTH_BITS = 31
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               in_byte,
   input  logic [31:0]              magic_word,
   input  logic [mlpd_pkg::MaxLenBits-1:0] max_length,
   output logic                     res_valid,
   output mlpd_pkg::result_type     res
);
   import mlpd_pkg::*;

   localparam logic [MaxLenBits-1:0] LenOverMask =
      ~((MaxLenBits'(1) << LENGTH_BITS) - MaxLenBits'(1));

   logic                   in_payload_ff, in_payload_in;
   logic [CountBits-1:0]   header_count_ff, header_count_in;
   logic [HeaderBits-1:0]  header_bytes_ff, header_bytes_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;

   logic [31:0] magic;
   logic [31:0] len;
   logic        last;
   logic        len_bad;

   assign magic   = header_bytes_ff[HeaderBits-1 -: 32];
   assign len     = {header_bytes_ff[23:0], in_byte};
   assign last    = (bytes_left_ff <= LENGTH_BITS'(1));
   assign len_bad = len[31] || (len[MaxLenBits-1:0] > max_length)
                    || ((len[MaxLenBits-1:0] & LenOverMask) != '0);

   always_comb begin
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      header_bytes_in = header_bytes_ff;
      bytes_left_in   = bytes_left_ff;
      res_valid       = 1'b0;
      res.out_byte    = 8'd0;
      res.out_last    = 1'b0;
      res.out_kind    = KindPayload;

      if (in_payload_ff) begin
         res_valid    = 1'b1;
         res.out_byte = in_byte;
         res.out_last = last;
         if (last) begin
            in_payload_in = 1'b0;
            bytes_left_in = '0;
         end else begin
            bytes_left_in = bytes_left_ff - LENGTH_BITS'(1);
         end
      end else if (header_count_ff != LastHeaderCount) begin
         header_bytes_in = {header_bytes_ff[HeaderBits-9:0], in_byte};
         header_count_in = header_count_ff + CountBits'(1);
      end else begin
         header_count_in = '0;
         res_valid       = 1'b1;
         if (magic != magic_word) begin
            res.out_kind = KindBadMagic;
         end else if (len_bad) begin
            res.out_kind = KindBadLength;
         end else if (len == 32'd0) begin
            res.out_kind = KindEmpty;
            res.out_last = 1'b1;
         end else begin
            res_valid     = 1'b0;
            in_payload_in = 1'b1;
            bytes_left_in = len[LENGTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= '0;
         bytes_left_ff   <= '0;
      end else if (step) begin
         in_payload_ff   <= in_payload_in;
         header_count_ff <= header_count_in;
         bytes_left_ff   <= bytes_left_in;
      end
      if (step) begin
         header_bytes_ff <= header_bytes_in;
      end
   end

`ifndef ASSERT_OFF
   a_payload_no_count: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> header_count_ff == '0)
      else $error("header count nonzero in payload");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> bytes_left_ff != '0)
      else $error("payload with no bytes left");

   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      !in_payload_ff && header_count_ff != LastHeaderCount |-> !res_valid)
      else $error("result during header gather");

   a_enter_payload: assert property (@(posedge clock) disable iff (reset)
      step && !in_payload_ff && in_payload_in |=> in_payload_ff && header_count_ff == '0)
      else $error("payload entry lost");
`endif
endmodule

FILE: src/mlpd_out_stage.sv
module mlpd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mlpd_pkg::result_type load_res,
   input  logic                 sink_ready,
   output logic                 free,
   output logic                 word_valid,
   output mlpd_pkg::result_type word_res
);
   import mlpd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign free = !valid_ff || sink_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (valid_ff && sink_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         res_in   = load_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign word_valid = valid_ff;
   assign word_res   = res_ff;
endmodule

FILE: src/magic_length_prefixed_deframer.sv
// A word accepted on req passes through the input register and then the result register before it appears on rsp.
// Throughput: one word per cycle while rsp takes results; the first seven header words and a header word
// that opens a payload give no result, so rsp carries at most one word per input.
// Input register and result register each hold one word; req stalls only when both are full.
// Reset (synchronous, active high) returns to header hunt and restores both
// registers: magic word 0x5443504D, max length 0x7FFFFFFF.
module magic_length_prefixed_deframer #(
   parameter int unsigned LENGTH_BITS = 31
) (
   input  logic       clock,
   input  logic       reset,
   mlpd_req_if.sink   req_chan,
   mlpd_rsp_if.source rsp_chan,
   mlpd_csr_if.sink   csr_chan
);
   import mlpd_pkg::*;

   logic [31:0]           magic_word_ff;
   logic [MaxLenBits-1:0] max_length_ff;

   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_free;
   logic       step;
   logic       res_valid;
   result_type res;
   result_type out_res;
   logic       out_valid;

   assign step           = in_valid && out_free;
   assign req_chan.ready = !in_valid || step;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= MagicReset;
         max_length_ff <= MaxLenReset;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CsrMagicWord: magic_word_ff <= csr_chan.data;
            CsrMaxLength: max_length_ff <= csr_chan.data[MaxLenBits-1:0];
            default: ;
         endcase
      end
   end

   mlpd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .load       (req_chan.valid && req_chan.ready),
      .load_byte  (req_chan.in_byte),
      .take       (step),
      .word_valid (in_valid),
      .word_byte  (in_byte)
   );

   mlpd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .in_byte    (in_byte),
      .magic_word (magic_word_ff),
      .max_length (max_length_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   mlpd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step && res_valid),
      .load_res   (res),
      .sink_ready (rsp_chan.ready),
      .free       (out_free),
      .word_valid (out_valid),
      .word_res   (out_res)
   );

   assign rsp_chan.valid    = out_valid;
   assign rsp_chan.out_byte = out_res.out_byte;
   assign rsp_chan.out_last = out_res.out_last;
   assign rsp_chan.out_kind = out_res.out_kind;

`ifndef ASSERT_OFF
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_res.out_kind == KindEmpty |-> out_res.out_last)
      else $error("empty message without last");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_res.out_kind == KindBadMagic || out_res.out_kind == KindBadLength)
      |-> !out_res.out_last && out_res.out_byte == 8'd0)
      else $error("status word carries data");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid && !out_free |=> in_valid && $stable(in_byte))
      else $error("input word lost while output full");
`endif
endmodule

FILE: tb/deframe_tb_pkg.sv
package deframe_tb_pkg;
   import mlpd_pkg::*;

   class deframe_scoreboard;
      logic [31:0]           magic_word;
      logic [MaxLenBits-1:0] max_len;
      bit                    in_payload;
      logic [CountBits-1:0]  hdr_count;
      logic [HeaderBits-1:0] hdr_bytes;
      logic [MaxLenBits-1:0] bytes_left;
      result_type            due_words[$];
      int unsigned           n_inputs;
      int unsigned           n_results;
      int unsigned           n_errors;
      int unsigned           kind_count[4];

      function void reset_state();
         magic_word = MagicReset;
         max_len    = MaxLenReset;
         in_payload = 1'b0;
         hdr_count  = '0;
         hdr_bytes  = '0;
         bytes_left = '0;
      endfunction

      function void write_reg(logic [CsrIdxBits-1:0] idx, logic [CsrDataBits-1:0] data);
         if (idx == CsrMagicWord) begin
            magic_word = data;
         end else if (idx == CsrMaxLength) begin
            max_len = data[MaxLenBits-1:0];
         end
      endfunction

      // advance the deframer state by one accepted byte
      function void note_input(logic [7:0] b);
         logic [63:0] full;
         logic [31:0] len;
         result_type  want;
         n_inputs++;
         want.out_byte = 8'h00;
         want.out_last = 1'b0;
         want.out_kind = KindPayload;
         if (in_payload) begin
            want.out_byte = b;
            want.out_last = (bytes_left <= 1);
            due_words.push_back(want);
            if (want.out_last) begin
               in_payload = 1'b0;
               bytes_left = '0;
            end else begin
               bytes_left = bytes_left - 1'b1;
            end
         end else if (hdr_count < LastHeaderCount) begin
            hdr_bytes = {hdr_bytes[HeaderBits-9:0], b};
            hdr_count = hdr_count + 1'b1;
         end else begin
            full      = {hdr_bytes, b};
            len       = full[31:0];
            hdr_count = '0;
            hdr_bytes = '0;
            if (full[63:32] != magic_word) begin
               want.out_kind = KindBadMagic;
               due_words.push_back(want);
            end else if (len[31] || len[MaxLenBits-1:0] > max_len) begin
               want.out_kind = KindBadLength;
               due_words.push_back(want);
            end else if (len == 32'd0) begin
               want.out_kind = KindEmpty;
               want.out_last = 1'b1;
               due_words.push_back(want);
            end else begin
               bytes_left = len[MaxLenBits-1:0];
               in_payload = 1'b1;
            end
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         n_results++;
         if (due_words.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("ERROR: unexpected word byte %02h last %0b kind %0d",
                        got.out_byte, got.out_last, got.out_kind);
            return;
         end
         want = due_words.pop_front();
         kind_count[want.out_kind]++;
         if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
             got.out_kind !== want.out_kind) begin
            n_errors++;
            if (n_errors <= 10)
               $display("ERROR: word %0d expected byte %02h last %0b kind %0d, got %02h %0b %0d",
                        n_results, want.out_byte, want.out_last, want.out_kind,
                        got.out_byte, got.out_last, got.out_kind);
         end
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;
   import mlpd_pkg::*;
   import deframe_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrIdxBits-1:0] CsrSpare2 = 2'd2;
   localparam logic [CsrIdxBits-1:0] CsrSpare3 = 2'd3;
   localparam int unsigned HoldOffCycles = 64;
   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned CycleLimit    = 400000;

   logic clock;
   logic reset = 1'b1;

   mlpd_req_if req_bus ();
   mlpd_rsp_if rsp_bus ();
   mlpd_csr_if csr_bus ();

   deframe_scoreboard sb;
   bit                req_burst;
   int unsigned       cycles;

   magic_length_prefixed_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_input(b);
   endtask

   task automatic send_header(input logic [31:0] magic, input logic [31:0] len);
      logic [63:0] hdr;
      hdr = {magic, len};
      for (int i = 7; i >= 0; i--) send_byte(hdr[i*8 +: 8]);
   endtask

   task automatic write_csr(input logic [CsrIdxBits-1:0] idx,
                            input logic [CsrDataBits-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic set_config(input logic [31:0] magic, input logic [MaxLenBits-1:0] max_len);
      write_csr(CsrIdxBits'($urandom_range(CsrSpare2, CsrSpare3)), $urandom);
      write_csr(CsrMagicWord, magic);
      write_csr(CsrMaxLength, {1'($urandom), max_len});
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // mostly aligned frames; every item starts once the deframer is hunting at byte 0
   task automatic run_traffic(input int unsigned n_items);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned k;
      logic [31:0] len;
      logic [31:0] lim;
      logic [31:0] top;
      logic [31:0] magic;
      stop_at = sb.n_inputs + n_items;
      while (sb.n_inputs < stop_at) begin
         while (sb.in_payload || sb.hdr_count != 0) send_byte(8'($urandom));
         lim  = {1'b0, sb.max_len};
         top  = (lim < 12) ? lim : 32'd12;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if (lim == 0)
               len = 32'd1;
            else if ($urandom_range(0, 15) == 0)
               len = (lim <= 64) ? lim : 32'($urandom_range(13, 64));
            else
               len = $urandom_range(1, top);
            send_header(sb.magic_word, len);
            while (sb.in_payload) send_byte(8'($urandom));
         end else if (pick < 62) begin
            send_header(sb.magic_word, 32'd0);
         end else if (pick < 72) begin
            magic = $urandom_range(0, 1) ? sb.magic_word ^ (32'h1 << $urandom_range(0, 31))
                                         : $urandom;
            send_header(magic, $urandom);
         end else if (pick < 78) begin
            send_header(sb.magic_word, {1'b1, 31'($urandom)});
         end else if (pick < 85) begin
            if (lim == 32'h7FFF_FFFF)
               len = {1'b1, 31'($urandom)};
            else if ($urandom_range(0, 1))
               len = lim + 1;
            else
               len = $urandom_range(lim + 1, 32'h7FFF_FFFF);
            send_header(sb.magic_word, len);
         end else if (pick < 93) begin
            // cut-off message: the next header is swallowed, at least in part, as payload
            if (lim >= 2) begin
               len = $urandom_range(2, (top < 2) ? 2 : top);
               send_header(sb.magic_word, len);
               k = $urandom_range(0, len - 1);
               repeat (k) send_byte(8'($urandom));
               send_header(sb.magic_word, {1'b1, 31'($urandom)});
            end else begin
               send_header(sb.magic_word, 32'd0);
            end
         end else begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin : rsp_side
      int unsigned stall;
      int unsigned taken;
      bit          burst;
      result_type  got;
      taken = 0;
      burst = 1'b0;
      rsp_bus.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) burst = !burst;
         stall = burst ? 0 : $urandom_range(0, 4);
         if (taken == 150 || taken == 700) stall = HoldOffCycles;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.out_byte = rsp_bus.out_byte;
         got.out_last = rsp_bus.out_last;
         got.out_kind = kind_type'(rsp_bus.out_kind);
         sb.check_result(got);
         taken++;
      end
   end

   initial begin
      sb = new();
      sb.reset_state();
      req_burst       = 1'b0;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= 8'h00;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CsrMagicWord;
      csr_bus.data    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-byte message, empty message, then bad magic together with a negative length
      send_header(MagicReset, 32'd1);
      send_byte(8'hFF);
      send_header(MagicReset, 32'd0);
      send_header(32'h0000_0000, 32'h8000_0000);
      run_traffic(220);
      wait_idle();

      set_config(32'hFFFF_FFFF, 31'h0);
      run_traffic(230);
      wait_idle();

      set_config(32'h0000_0000, 31'h7FFF_FFFF);
      run_traffic(260);
      wait_idle();

      set_config($urandom, 31'($urandom_range(1, 20)));
      run_traffic(260);
      wait_idle();

      set_config($urandom, 31'($urandom));
      run_traffic(260);
      wait_idle();

      $display("Sent %0d bytes under 5 register settings, limits from 0 to the maximum.",
               sb.n_inputs);
      $display("Checked %0d words: %0d payload, %0d empty, %0d bad magic, %0d bad length.",
               sb.n_results, sb.kind_count[KindPayload], sb.kind_count[KindEmpty],
               sb.kind_count[KindBadMagic], sb.kind_count[KindBadLength]);
      if (sb.n_errors == 0 && sb.due_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d errors, %0d words still expected", sb.n_errors, sb.due_words.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: magic_length_prefixed_deframer.f
src/mlpd_pkg.sv
src/mlpd_if.sv
src/mlpd_in_stage.sv
src/mlpd_parser.sv
src/mlpd_out_stage.sv
src/magic_length_prefixed_deframer.sv
tb/deframe_tb_pkg.sv
tb/tb_top.sv
